### sv/lcdseq_pkg.sv
package lcdseq_pkg;

    // operation codes on the mode field
    localparam logic [2:0] MODE_INIT   = 3'd0;
    localparam logic [2:0] MODE_CLEAR  = 3'd1;
    localparam logic [2:0] MODE_CURSOR = 3'd2;
    localparam logic [2:0] MODE_CHAR   = 3'd3;
    localparam logic [2:0] MODE_FLAG   = 3'd4;

    // flag_select codes
    localparam logic [1:0] FLAG_DISPLAY = 2'd0;
    localparam logic [1:0] FLAG_CURSOR  = 2'd1;
    localparam logic [1:0] FLAG_BLINK   = 2'd2;

    // command bytes and bits
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] ROW1_OFFSET   = 8'h40;
    localparam logic [3:0] CTRL_INIT     = 4'hC;
    localparam logic [3:0] BIT_DISPLAY   = 4'h4;
    localparam logic [3:0] BIT_CURSOR    = 4'h2;
    localparam logic [3:0] BIT_BLINK     = 4'h1;
    localparam logic [7:0] MAX_ROW       = 8'd1;
    localparam logic [7:0] MAX_COL       = 8'd15;

    // waits in microseconds
    localparam logic [15:0] DELAY_NIB     = 16'd50;
    localparam logic [15:0] DELAY_LONG    = 16'd2050;
    localparam logic [15:0] DELAY_POWERUP = 16'd50000;
    localparam logic [15:0] DELAY_WAKE1   = 16'd5050;
    localparam logic [15:0] DELAY_WAKE    = 16'd200;

    // bus writes of the init sequence
    localparam int INIT_WRITES = 13;
    localparam int STEP_W      = $clog2(INIT_WRITES);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // classified operation, as queued
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] byte_val;
        logic       long_wait;
    } op_t;

    // queue status seen by front and back
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

    // one bus write
    typedef struct packed {
        logic        strobe;
        logic        rs;
        logic [3:0]  nibble;
        logic [15:0] delay;
        logic        last;
    } wr_t;

    function automatic wr_t init_write(input logic [STEP_W-1:0] step);
        wr_t w;
        w.strobe = 1'b1;
        w.rs     = 1'b0;
        w.nibble = 4'h0;
        w.delay  = DELAY_NIB;
        w.last   = 1'b0;
        case (step)
            4'd0:
            begin
                w.strobe = 1'b0;
                w.delay  = DELAY_POWERUP;
            end
            4'd1:
            begin
                w.nibble = 4'h3;
                w.delay  = DELAY_WAKE1;
            end
            4'd2, 4'd3:
            begin
                w.nibble = 4'h3;
                w.delay  = DELAY_WAKE;
            end
            4'd4:
            begin
                w.nibble = 4'h2;
                w.delay  = DELAY_WAKE;
            end
            4'd5:    w.nibble = 4'h2;    // function set 0x28
            4'd6:    w.nibble = 4'h8;
            4'd7:    w.nibble = 4'h0;    // display control 0x0C
            4'd8:    w.nibble = CTRL_INIT;
            4'd9:    w.nibble = 4'h0;    // clear 0x01
            4'd10:
            begin
                w.nibble = 4'h1;
                w.delay  = DELAY_LONG;
            end
            4'd11:   w.nibble = 4'h0;    // entry mode 0x06
            4'd12:
            begin
                w.nibble = 4'h6;
                w.delay  = DELAY_LONG;
                w.last   = 1'b1;
            end
            default:
            begin
                w.nibble = 4'h6;
                w.delay  = DELAY_LONG;
                w.last   = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

### sv/lcdseq_front.sv
module lcdseq_front
    import lcdseq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] mode,
    input  logic [7:0] row,
    input  logic [7:0] col,
    input  logic [7:0] char_code,
    input  logic [1:0] flag_select,
    input  logic       flag_value,
    input  q_stat_t    q_stat,
    output logic       push,
    output op_t        push_op
);

    logic [3:0] ctrl_reg;
    logic [3:0] ctrl_next;
    logic [3:0] flag_bit;
    logic [3:0] ctrl_flag;
    logic [7:0] row_c;
    logic [3:0] col_c;
    logic       accept;
    logic       known;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        case (flag_select)
            FLAG_DISPLAY: flag_bit = BIT_DISPLAY;
            FLAG_CURSOR:  flag_bit = BIT_CURSOR;
            FLAG_BLINK:   flag_bit = BIT_BLINK;
            default:      flag_bit = 4'h0;
        endcase
        ctrl_flag = flag_value ? (ctrl_reg | flag_bit) : (ctrl_reg & ~flag_bit);
        row_c = (row > MAX_ROW) ? MAX_ROW : row;
        col_c = (col > MAX_COL) ? MAX_COL[3:0] : col[3:0];
    end

    always_comb
    begin
        push_op.is_init   = 1'b0;
        push_op.rs        = 1'b0;
        push_op.byte_val  = CMD_CLEAR;
        push_op.long_wait = 1'b0;
        known             = 1'b1;
        ctrl_next         = ctrl_reg;
        case (mode)
            MODE_INIT:
            begin
                push_op.is_init = 1'b1;
                ctrl_next       = CTRL_INIT;
            end
            MODE_CLEAR:
            begin
                push_op.long_wait = 1'b1;
            end
            MODE_CURSOR:
            begin
                push_op.byte_val = CMD_SET_DDRAM | (row_c[0] ? ROW1_OFFSET : 8'h00)
                                   | {4'h0, col_c};
            end
            MODE_CHAR:
            begin
                push_op.rs       = 1'b1;
                push_op.byte_val = char_code;
            end
            MODE_FLAG:
            begin
                ctrl_next        = ctrl_flag;
                push_op.byte_val = {4'h0, ctrl_flag};
            end
            default: known = 1'b0;   // unused modes are dropped
        endcase
    end

    assign push = accept && known;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= 4'h0;
        else if (accept)
            ctrl_reg <= ctrl_next;
    end

endmodule

### sv/lcdseq_queue.sv
module lcdseq_queue
    import lcdseq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  op_t     push_op,
    input  logic    pop,
    output op_t     head,
    output q_stat_t q_stat
);

    op_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head             = mem_reg[rd_ptr_reg];
    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

endmodule

### sv/lcdseq_back.sv
module lcdseq_back
    import lcdseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     q_stat,
    input  op_t         head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        strobe_res,
    output logic        reg_select,
    output logic [3:0]  nibble,
    output logic [15:0] delay_us,
    output logic        last
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    wr_t               wr;
    wr_t               wr_reg;
    logic              out_load;

    // next bus write for the operation at the queue head
    always_comb
    begin
        if (head.is_init)
            wr = init_write(step_reg);
        else
        begin
            wr.strobe = 1'b1;
            wr.rs     = head.rs;
            if (!step_reg[0])
            begin
                wr.nibble = head.byte_val[7:4];
                wr.delay  = DELAY_NIB;
                wr.last   = 1'b0;
            end
            else
            begin
                wr.nibble = head.byte_val[3:0];
                wr.delay  = head.long_wait ? DELAY_LONG : DELAY_NIB;
                wr.last   = 1'b1;
            end
        end
    end

    assign out_load       = q_stat.not_empty && (!out_valid_reg || out_ready);
    assign pop            = out_load && wr.last;
    assign step_next      = out_load ? (wr.last ? '0 : step_reg + 1'b1) : step_reg;
    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            wr_reg <= wr;
    end

    assign out_valid  = out_valid_reg;
    assign strobe_res = wr_reg.strobe;
    assign reg_select = wr_reg.rs;
    assign nibble     = wr_reg.nibble;
    assign delay_us   = wr_reg.delay;
    assign last       = wr_reg.last;

`ifndef ASSERT_OFF
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(INIT_WRITES - 1))
        else $error("sequence step out of range");

    a_short_op: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.not_empty && !head.is_init |-> step_reg <= STEP_W'(1))
        else $error("byte operation beyond two writes");

    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> step_reg == '0)
        else $error("step not reset after last write");
`endif

endmodule

### sv/char_lcd_nibble_command_sequencer_top.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   mode, row, col, char_code, flag_select, flag_value
// output    out        out_valid / out_ready strobe_res, reg_select, nibble, delay_us, last
//
// One bus write leaves per cycle while out_ready is high and the queue
// holds an operation: an operation gives two nibble writes (init 13), each
// loaded into the back end's output register. The front takes an operation
// each cycle while the two-entry queue has room, so it keeps accepting
// during output stalls. Reset clears the queue, the write step, the output
// valid and the kept display control byte (0 until an init or flag operation
// is accepted). Unused modes are accepted and give no writes.
module char_lcd_nibble_command_sequencer_top
    import lcdseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [7:0]  row,
    input  logic [7:0]  col,
    input  logic [7:0]  char_code,
    input  logic [1:0]  flag_select,
    input  logic        flag_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        strobe_res,
    output logic        reg_select,
    output logic [3:0]  nibble,
    output logic [15:0] delay_us,
    output logic        last
);

    // front to queue transfer
    logic    push;
    op_t     push_op;
    // queue to back
    logic    pop;
    op_t     head;
    q_stat_t q_stat;

    // front: classifies operations, keeps the display control byte
    lcdseq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .row         (row),
        .col         (col),
        .char_code   (char_code),
        .flag_select (flag_select),
        .flag_value  (flag_value),
        .q_stat      (q_stat),
        .push        (push),
        .push_op     (push_op)
    );

    // short queue decoupling front and back
    lcdseq_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .q_stat  (q_stat)
    );

    // back: steps through the nibble writes of the head operation
    lcdseq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .strobe_res (strobe_res),
        .reg_select (reg_select),
        .nibble     (nibble),
        .delay_us   (delay_us),
        .last       (last)
    );

endmodule
